### rtl/core/mpbm_pkg.sv
// shared types and constants of the multi pattern byte matcher
// used by the front, back and core modules, no dependencies
`timescale 1ns / 1ps

package mpbm_pkg;

  localparam int unsigned BYTE_BITS         = 8;
  localparam int unsigned PATTERN_WORD_BITS = 64;
  localparam int unsigned LENGTH_BITS       = 4;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned MATCH_OFFSET_BITS = 32;
  localparam int unsigned PATTERN_NUM_BITS  = 3;
  localparam int unsigned IN_TDATA_BITS     = 8;
  localparam int unsigned OUT_PAD_BITS      = 1;
  localparam int unsigned OUT_TDATA_BITS    = 40;
  localparam int unsigned QUEUE_DEPTH       = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_A = 3'd0,
    REG_PATTERN_B = 3'd1,
    REG_PATTERN_C = 3'd2,
    REG_PATTERN_D = 3'd3,
    REG_LENGTH_A  = 3'd4,
    REG_LENGTH_B  = 3'd5,
    REG_LENGTH_C  = 3'd6,
    REG_LENGTH_D  = 3'd7
  } cfg_index_e;

  // first field in the highest bits
  typedef struct packed {
    logic [OUT_PAD_BITS-1:0]      pad;
    logic [PATTERN_NUM_BITS-1:0]  pattern_number;
    logic [LENGTH_BITS-1:0]       match_length;
    logic [MATCH_OFFSET_BITS-1:0] match_offset;
  } match_result_t;

endpackage

### rtl/core/mpbm_front.sv
// front end: pattern registers, byte window, position and per-pattern gap tracking
// classifies each item and pushes the byte's hit mask into the queue; uses mpbm_pkg
`timescale 1ns / 1ps

module mpbm_front #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned PATTERN_COUNT     = 4,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mpbm_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [mpbm_pkg::PATTERN_WORD_BITS-1:0]  cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [mpbm_pkg::BYTE_BITS-1:0]          in_byte_i,
  input  logic                                    in_sob_i,
  output logic                                    push_o,
  output logic [OFFSET_BITS+PATTERN_COUNT-1:0]    push_data_o,
  input  logic                                    full_i,
  output logic [PATTERN_COUNT-1:0][mpbm_pkg::LENGTH_BITS-1:0] lens_o
);
  import mpbm_pkg::*;

  localparam int unsigned IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [LENGTH_BITS-1:0] MAX_LEN = LENGTH_BITS'(MAX_PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [PATTERN_COUNT-1:0][PATTERN_WORD_BITS-1:0] pat_q;
  logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0]       len_q;
  logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0]       len_clamp;
  logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0]       avail_q, avail_d;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0]     win_q, win_d, win_base;
  logic [OFFSET_BITS-1:0]                          pos_q, pos_d, pos_base;
  logic [PATTERN_COUNT-1:0]                        hit;
  logic                                            accept;
  logic                                            saturated;

  always_comb begin
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      len_clamp[p] = (len_q[p] > MAX_LEN) ? MAX_LEN : len_q[p];
    end
  end

  assign lens_o     = len_clamp;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // start of buffer clears history before the byte is taken in
  assign pos_base  = in_sob_i ? '0 : pos_q;
  assign win_base  = in_sob_i ? '0 : win_q;
  assign saturated = (pos_base == POS_MAX);
  assign pos_d     = pos_base + 1'b1;

  always_comb begin
    win_d[0] = in_byte_i;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_d[j] = win_base[j-1];
    end
  end

  always_comb begin
    logic [LENGTH_BITS-1:0]       avail_base;
    logic [LENGTH_BITS-1:0]       avail_inc;
    logic [IDX_BITS-1:0]          idx;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      avail_base = in_sob_i ? '0 : avail_q[p];
      avail_inc  = (avail_base >= MAX_LEN) ? MAX_LEN : avail_base + 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        // pattern byte i sits len-1-i bytes back from the newest one
        idx = IDX_BITS'(len_clamp[p] - LENGTH_BITS'(i + 1));
        byte_ok[i] = (LENGTH_BITS'(i) >= len_clamp[p]) ||
                     (win_d[idx] == pat_q[p][BYTE_BITS*i +: BYTE_BITS]);
      end
      hit[p]     = (len_clamp[p] != '0) && (avail_inc >= len_clamp[p]) && (&byte_ok);
      avail_d[p] = hit[p] ? '0 : avail_inc;
    end
  end

  assign push_o      = accept && !saturated && (|hit);
  assign push_data_o = {hit, pos_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= '0;
    end else if (cfg_we_i) begin
      for (int p = 0; p < PATTERN_COUNT; p++) begin
        if (cfg_index_i == CFG_INDEX_BITS'(REG_PATTERN_A) + CFG_INDEX_BITS'(p)) begin
          pat_q[p] <= cfg_data_i;
        end
        if (cfg_index_i == CFG_INDEX_BITS'(REG_LENGTH_A) + CFG_INDEX_BITS'(p)) begin
          len_q[p] <= cfg_data_i[LENGTH_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      avail_q <= '0;
    end else if (accept && !saturated) begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      avail_q <= avail_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_front_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into a full queue");

  a_front_gap_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !saturated && hit[0]) |=> (avail_q[0] == '0))
    else $error("gap counter not cleared after a match");
`endif

endmodule

### rtl/core/mpbm_queue.sv
// small first-in first-out queue between the front and back ends
// generic width and depth, no package dependency beyond the timescale
`timescale 1ns / 1ps

module mpbm_queue #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_BITS:0] DEPTH_CNT = (PTR_BITS + 1)'(DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PTR_BITS-1:0]         wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]           count_q;

  assign full_o     = (count_q == DEPTH_CNT);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  a_queue_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("queue count beyond depth");
`endif

endmodule

### rtl/core/mpbm_back.sv
// back end: walks each queued hit mask in pattern order, one result per cycle while the
// output is ready; computes the start offset, drives the registered output stage; uses mpbm_pkg
`timescale 1ns / 1ps

module mpbm_back #(
  parameter int unsigned PATTERN_COUNT = 4,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  logic [OFFSET_BITS+PATTERN_COUNT-1:0] q_data_i,
  output logic                                 pop_o,
  input  logic [PATTERN_COUNT-1:0][mpbm_pkg::LENGTH_BITS-1:0] lens_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mpbm_pkg::match_result_t              out_data_o,
  output logic                                 out_last_o
);
  import mpbm_pkg::*;

  localparam int unsigned PIDX_BITS = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;

  logic                     cur_valid_q;
  logic [PATTERN_COUNT-1:0] cur_mask_q;
  logic [OFFSET_BITS-1:0]   cur_pos_q;
  logic                     out_valid_q;
  match_result_t            out_data_q;
  logic                     out_last_q;

  logic                     out_free;
  logic                     issue;
  logic [PATTERN_COUNT-1:0] sel;
  logic [PATTERN_COUNT-1:0] rest;
  logic                     is_last;
  logic [PIDX_BITS-1:0]     sel_idx;
  logic [LENGTH_BITS-1:0]   sel_len;
  logic [OFFSET_BITS-1:0]   start;

  assign out_free = !out_valid_q || out_ready_i;
  assign issue    = cur_valid_q && out_free;
  assign sel      = cur_mask_q & (~cur_mask_q + 1'b1);
  assign rest     = cur_mask_q & ~sel;
  assign is_last  = (rest == '0);

  always_comb begin
    sel_idx = '0;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      if (sel[p]) begin
        sel_idx = PIDX_BITS'(p);
      end
    end
  end

  assign sel_len = lens_i[sel_idx];
  // queued position is one past the byte that completed the match
  assign start   = cur_pos_q - OFFSET_BITS'(sel_len);
  assign pop_o   = q_valid_i && (!cur_valid_q || (issue && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (issue && is_last) begin
        cur_valid_q <= 1'b0;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_mask_q <= q_data_i[OFFSET_BITS +: PATTERN_COUNT];
      cur_pos_q  <= q_data_i[OFFSET_BITS-1:0];
    end else if (issue) begin
      cur_mask_q <= rest;
    end
    if (issue) begin
      out_data_q.pad            <= '0;
      out_data_q.pattern_number <= PATTERN_NUM_BITS'(sel_idx) + 1'b1;
      out_data_q.match_length   <= sel_len;
      out_data_q.match_offset   <= MATCH_OFFSET_BITS'(start);
      out_last_q                <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_back_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_mask_q != '0))
    else $error("active entry with an empty hit mask");

  a_back_single_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> $onehot(sel))
    else $error("result issued without a single selected pattern");
`endif

endmodule

### rtl/core/multi_pattern_byte_matcher_core.sv
// Searches a byte stream for up to four configured byte patterns of up to eight bytes each.
// Channels: s_axis carries one buffer byte per item, s_axis_tuser set on the first byte of a
// buffer. m_axis carries one match per item; tlast marks the final match for a byte, and
// several matches on one byte come out in pattern order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (patterns 0..3,
// lengths 4..7); write only while no item is in flight. A length of zero disables a pattern.
// Throughput: one byte per cycle. The back end emits one match per cycle while m_axis is
// ready, so a byte that completes several patterns holds the back end until all its matches
// are out. A four-entry queue absorbs this; s_axis_tready drops only when the queue is full.
// A match passes through the queue, the current-entry register and the output register.
// Once the position counter reaches its maximum, further bytes are taken but ignored
// until the next start of buffer.
// Reset clears patterns, lengths, window, position and the queue; s_axis is ready right away.
// A stalled m_axis_tready holds the current match and backs up the queue, then s_axis.
// Uses mpbm_pkg, mpbm_front, mpbm_queue and mpbm_back.
`timescale 1ns / 1ps

module multi_pattern_byte_matcher_core #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned PATTERN_COUNT     = 4,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mpbm_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [mpbm_pkg::PATTERN_WORD_BITS-1:0] cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [mpbm_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,  // data_byte
  input  logic                                   s_axis_tuser,  // start_of_buffer
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // match_offset[31:0], match_length[35:32], pattern_number[38:36], zero[39]
  output logic [mpbm_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
  output logic                                   m_axis_tlast   // last_of_run
);
  import mpbm_pkg::*;

  localparam int unsigned ENTRY_BITS = OFFSET_BITS + PATTERN_COUNT;

  logic                                      push;
  logic [ENTRY_BITS-1:0]                     push_data;
  logic                                      full;
  logic                                      pop;
  logic [ENTRY_BITS-1:0]                     pop_data;
  logic                                      q_valid;
  logic [PATTERN_COUNT-1:0][LENGTH_BITS-1:0] lens;
  match_result_t                             result;

  mpbm_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .PATTERN_COUNT     (PATTERN_COUNT),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_sob_i    (s_axis_tuser),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full),
    .lens_o      (lens)
  );

  mpbm_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (q_valid)
  );

  mpbm_back #(
    .PATTERN_COUNT (PATTERN_COUNT),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .lens_i      (lens),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = result;

endmodule
